/* sv/sha_pkg.sv */
// sha-256 engine package: round constants, initial hash values, helpers
// no dependencies
`timescale 1ns / 1ps
package sha_pkg;
	localparam int unsigned BLK_BYTES = 64;
	localparam logic [63:0] LEN_LIMIT = 64'h1FFF_FFFF_FFFF_FFFF;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

/* sv/sha_core.sv */
// sha-256 compression core: one round per cycle over a 16-word schedule window; rounds 0..15 wait for their word
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,     // pulse to load h_in and restart the rounds; words follow on word_vld
	input  logic                 word_vld,  // message word for rounds 0..15
	input  logic [31:0]          word_in,
	input  logic [7:0][31:0]     h_in,
	output logic [7:0][31:0]     h_out,
	output logic                 done
);
	import sha_pkg::*;

	logic [7:0][31:0]  v_q;
	logic [15:0][31:0] w_q;
	logic [6:0]        rnd_q;
	logic              busy_q;
	logic [31:0]       w_cur, t1, t2, s0, s1, e, a, p, q;

	// schedule word and t1, t2 for this round
	always_comb begin
		p = w_q[1];
		q = w_q[14];
		s0 = rotr(p, 7) ^ rotr(p, 18) ^ (p >> 3);
		s1 = rotr(q, 17) ^ rotr(q, 19) ^ (q >> 10);
		w_cur = (rnd_q < 7'd16) ? word_in : (w_q[0] + s0 + w_q[9] + s1);
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + round_k(rnd_q[5:0]) + w_cur;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// round sequencer; rounds 0..15 wait for incoming words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q && (rnd_q >= 7'd16 || word_vld)) begin
				if (rnd_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= h_in;
		end else if (busy_q && (rnd_q >= 7'd16 || word_vld)) begin
			w_q <= {w_cur, w_q[15:1]};
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) h_out[i] = h_in[i] + v_q[i];
	end
endmodule

/* sv/sha256_hash_engine.sv */
// sha-256 engine top level: byte buffer memory, padding sequencer, digest output
// depends on sha_pkg, sha_core
`timescale 1ns / 1ps
// Usage:
// s_axis carries one item per request: tuser = req_type, tdata = data_byte.
// An append item is accepted while the engine is idle, so bytes can follow
// back to back. The 64th byte of a block starts a compression: the buffer
// memory is read back one byte per cycle (registered read), rounds 0..15
// each take a word once its four bytes are read and rounds 16..63 run one
// per cycle, and s_axis_tready stays low until the block is compressed. A
// finish item writes the 0x80 marker, pads zeros and the bit length in the
// buffer memory one byte a cycle, compresses one or two blocks, then emits
// eight digest words on m_axis (tdata = digest_word, tuser = word_index,
// last_word, length_error; tlast = last_word). An overflowed length gives
// a single error item instead. m_axis is a registered output; while the
// receiver stalls the word holds and the engine waits. After reset or a
// finish, hash words and counters take their initial values; the buffer
// contents are not cleared.
module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [4:0]  m_axis_tuser,   // [2:0] word_index, [3] last_word, [4] length_error
	output logic        m_axis_tlast
);
	import sha_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_PAD = 4'd1, ST_LEN = 4'd2, ST_RD = 4'd3,
		ST_RUN = 4'd4, ST_OUT = 4'd5, ST_WR = 4'd6, ST_ERR = 4'd7;

	logic [3:0]        st_q;
	logic [7:0]        mem [BLK_BYTES];
	logic [7:0]        rd_q;
	logic [5:0]        fill_q, ptr_q;
	logic [63:0]       bytes_q;
	logic              ovf_q, fin_q, two_q;
	logic [7:0][31:0]  h_q, h_out;
	logic [31:0]       word_q;
	logic [3:0]        rdw_q;   // word being read
	logic [1:0]        bsel_q;
	logic              rd_vld_q, wvld_q, start_q, done;
	logic [2:0]        oi_q;
	logic              we;
	logic [5:0]        waddr;
	logic [7:0]        wdata;
	logic [63:0]       bits;

	assign bits = {bytes_q[60:0], 3'b000};
	assign s_axis_tready = (st_q == ST_IDLE);

	// buffer memory write port
	always_comb begin
		we = 1'b0;
		waddr = fill_q;
		wdata = s_axis_tdata;
		case (st_q)
			ST_IDLE: we = s_axis_tvalid && !s_axis_tuser;
			ST_WR: begin
				we = 1'b1; wdata = 8'h80;
			end
			ST_PAD: begin
				we = 1'b1; waddr = ptr_q; wdata = 8'h00;
			end
			ST_LEN: begin
				we = 1'b1; waddr = ptr_q;
				wdata = bits[8 * (63 - ptr_q) +: 8];
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[{rdw_q, bsel_q}];
	end

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start_q), .word_vld(wvld_q),
		.word_in(word_q), .h_in(h_q), .h_out(h_out), .done(done)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			fill_q <= '0; bytes_q <= '0; ovf_q <= 1'b0; fin_q <= 1'b0; two_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
			m_axis_tvalid <= 1'b0;
			rdw_q <= '0; bsel_q <= '0; rd_vld_q <= 1'b0; wvld_q <= 1'b0;
			start_q <= 1'b0; ptr_q <= '0; oi_q <= '0; word_q <= '0;
		end else begin
			start_q <= 1'b0;
			wvld_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (s_axis_tvalid) begin
					if (!s_axis_tuser) begin
						if (bytes_q != '1) bytes_q <= bytes_q + 64'd1;
						if (bytes_q >= LEN_LIMIT) ovf_q <= 1'b1;
						fill_q <= fill_q + 6'd1;
						fin_q <= 1'b0;
						if (fill_q == 6'd63) begin
							st_q <= ST_RD; start_q <= 1'b1;
							rdw_q <= '0; bsel_q <= '0; rd_vld_q <= 1'b0;
						end
					end else if (ovf_q) begin
						st_q <= ST_ERR; m_axis_tvalid <= 1'b1;
					end else begin
						st_q <= ST_WR; fin_q <= 1'b1;
					end
				end
				ST_WR: begin
					ptr_q <= fill_q + 6'd1;
					two_q <= (fill_q >= 6'd56);
					if (fill_q == 6'd63) begin
						st_q <= ST_RD; start_q <= 1'b1;
						rdw_q <= '0; bsel_q <= '0; rd_vld_q <= 1'b0;
					end else if (fill_q == 6'd55) st_q <= ST_LEN;
					else st_q <= ST_PAD;
				end
				ST_PAD: begin
					ptr_q <= ptr_q + 6'd1;
					if (ptr_q == 6'd63) begin
						st_q <= ST_RD; start_q <= 1'b1;
						rdw_q <= '0; bsel_q <= '0; rd_vld_q <= 1'b0;
					end else if (ptr_q == 6'd55 && !two_q) st_q <= ST_LEN;
				end
				ST_LEN: begin
					ptr_q <= ptr_q + 6'd1;
					if (ptr_q == 6'd63) begin
						st_q <= ST_RD; start_q <= 1'b1; two_q <= 1'b0;
						rdw_q <= '0; bsel_q <= '0; rd_vld_q <= 1'b0;
					end
				end
				// stream 16 words out of the buffer, byte by byte
				ST_RD: begin
					rd_vld_q <= 1'b1;
					{rdw_q, bsel_q} <= {rdw_q, bsel_q} + 6'd1;
					if (rd_vld_q) begin
						word_q <= {word_q[23:0], rd_q};
						if (bsel_q == 2'd0) wvld_q <= 1'b1;
					end
					if (rd_vld_q && bsel_q == 2'd0 && rdw_q == 4'd0) st_q <= ST_RUN;
				end
				ST_RUN: if (done) begin
					if (two_q) begin
						h_q <= h_out; ptr_q <= '0; two_q <= 1'b0; st_q <= ST_PAD;
					end else if (fin_q) begin
						h_q <= h_out; oi_q <= '0; st_q <= ST_OUT;
						m_axis_tvalid <= 1'b1;
					end else begin
						h_q <= h_out; st_q <= ST_IDLE;
					end
				end
				ST_OUT: if (m_axis_tready) begin
					oi_q <= oi_q + 3'd1;
					if (oi_q == 3'd7) begin
						m_axis_tvalid <= 1'b0; st_q <= ST_IDLE;
						for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
						fill_q <= '0; bytes_q <= '0; ovf_q <= 1'b0; fin_q <= 1'b0;
					end
				end
				ST_ERR: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0; st_q <= ST_IDLE;
					for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
					fill_q <= '0; bytes_q <= '0; ovf_q <= 1'b0; fin_q <= 1'b0;
				end
				default: st_q <= ST_IDLE;
			endcase
			// the final word of a block arrives after the read wraps
			if (st_q == ST_RUN && rd_vld_q) begin
				rd_vld_q <= 1'b0;
			end
		end
	end

	// digest and error item output
	always_comb begin
		m_axis_tdata = (st_q == ST_ERR) ? 32'd0 : h_q[oi_q];
		m_axis_tuser = (st_q == ST_ERR) ? 5'b11000 : {1'b0, oi_q == 3'd7, oi_q};
		m_axis_tlast = m_axis_tuser[3];
	end
endmodule
